// ===== design/four_level_page_table_walker_top_defines.svh =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top_defines
// assertion macros for the page table walker checker
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FPTW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FPTW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/fptw_pkg.sv =====
// ----------------------------------------------------------------------------
// fptw_pkg
// shared types and constants of the four-level page table walker
// ----------------------------------------------------------------------------
package fptw_pkg;

	localparam int DEF_TABLE_PAGES = 64;
	localparam int DEF_PHYS_BITS   = 52;

	localparam int VA_W       = 64;
	localparam int PA_W       = 52;
	localparam int ENTRY_W    = 64;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int IDX_W      = 9;
	localparam int ENTRIES    = 512;
	localparam int PAGE_OFF_W = 12;

	// sign-extension field of a canonical address: bits 63:47
	localparam int CANON_LSB = 47;

	localparam logic [1:0] LEAF_LEVEL = 2'd3;
	localparam logic [1:0] ENT_TABLE  = 2'b11;  // present | writable

	typedef enum logic [OP_W-1:0] {
		OP_TRANSLATE = 2'd0,
		OP_MAP       = 2'd1,
		OP_UNMAP     = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NONCANON  = 3'd1,
		ST_NOTMAPPED = 3'd2,
		ST_MAPPED    = 3'd3,
		ST_NOPAGES   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_RD,
		S_EV,
		S_ZERO,
		S_LINK,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    rd;
		logic    descend;
		logic    alloc;
		logic    zero_wr;
		logic    link_wr;
		logic    leaf_wr;
		logic    clr_wr;
		logic    set_res;
		status_t res_code;
		logic    post;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_translate;
		logic is_map;
		logic is_unmap;
		logic noncanon;
		logic present;
		logic in_win;
		logic at_leaf;
		logic pages_left;
		logic zero_last;
		logic out_free;
	} stat_t;

endpackage

// ===== design/fptw_ctrl.sv =====
// ----------------------------------------------------------------------------
// fptw_ctrl
// sequencer of the walk: reads, allocation sweeps, entry writes, result
// ----------------------------------------------------------------------------
module fptw_ctrl import fptw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t st,
	output cmd_t  cmd,
	output logic  in_stall
);

	state_t state_q;
	state_t state_d;
	logic   op_known;

	assign op_known = st.is_translate | st.is_map | st.is_unmap;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (st.zero_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_START;
			end
			S_START: begin
				if (!op_known || st.noncanon) state_d = S_OUT;
				else state_d = S_RD;
			end
			S_RD: begin
				state_d = S_EV;
			end
			S_EV: begin
				if (st.at_leaf) state_d = S_OUT;
				else if (st.present && st.in_win) state_d = S_RD;
				else if (!st.present && st.is_map && st.pages_left) state_d = S_ZERO;
				else state_d = S_OUT;
			end
			S_ZERO: begin
				if (st.zero_last) state_d = S_LINK;
			end
			S_LINK: begin
				state_d = S_RD;
			end
			S_OUT: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.res_code = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.zero_wr = 1'b1;
			end
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_START: begin
				if (!op_known) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_OK;
				end else if (st.noncanon) begin
					cmd.set_res  = 1'b1;
					cmd.res_code = ST_NONCANON;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
			end
			S_EV: begin
				if (!st.at_leaf) begin
					if (st.present && st.in_win) begin
						cmd.descend = 1'b1;
					end else if (st.present) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_NOTMAPPED;
					end else if (!st.is_map) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_NOTMAPPED;
					end else if (!st.pages_left) begin
						cmd.set_res  = 1'b1;
						cmd.res_code = ST_NOPAGES;
					end else begin
						cmd.alloc = 1'b1;
					end
				end else begin
					cmd.set_res = 1'b1;
					if (st.is_map) begin
						if (st.present) begin
							cmd.res_code = ST_MAPPED;
						end else begin
							cmd.leaf_wr  = 1'b1;
							cmd.res_code = ST_OK;
						end
					end else begin
						// unmap clears the leaf whether or not it was present
						cmd.clr_wr   = st.is_unmap;
						cmd.res_code = st.present ? ST_OK : ST_NOTMAPPED;
					end
				end
			end
			S_ZERO: begin
				cmd.zero_wr = 1'b1;
			end
			S_LINK: begin
				cmd.link_wr = 1'b1;
			end
			S_OUT: begin
				cmd.post = st.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== design/fptw_dp.sv =====
// ----------------------------------------------------------------------------
// fptw_dp
// table store, walk registers, bump allocator and result registers
// ----------------------------------------------------------------------------
module fptw_dp import fptw_pkg::*; #(
	parameter int TABLE_PAGES = DEF_TABLE_PAGES,
	parameter int PHYS_BITS   = DEF_PHYS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               st,
	input  logic                cfg_we,
	input  logic [PA_W-1:0]     table_base,
	input  logic [OP_W-1:0]     op,
	input  logic [VA_W-1:0]     vaddr,
	input  logic [PA_W-1:0]     paddr,
	input  logic [ENTRY_W-1:0]  flags,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [PA_W-1:0]     paddr_out
);

	localparam int FW    = PHYS_BITS - PAGE_OFF_W;
	localparam int PW    = $clog2(TABLE_PAGES);
	localparam int NW    = $clog2(TABLE_PAGES + 1);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * ENTRIES;

	localparam logic [ENTRY_W-1:0] PHYS_MASK  = (ENTRY_W'(1) << PHYS_BITS) - ENTRY_W'(1);
	localparam logic [ENTRY_W-1:0] OFF_MASK   = (ENTRY_W'(1) << PAGE_OFF_W) - ENTRY_W'(1);
	localparam logic [ENTRY_W-1:0] FRAME_MASK = PHYS_MASK & ~OFF_MASK;

	logic [ENTRY_W-1:0]  mem [DEPTH];

	logic [FW-1:0]       base_q;
	logic [OP_W-1:0]     op_q;
	logic [VA_W-1:0]     va_q;
	logic [PA_W-1:0]     pa_q;
	logic [ENTRY_W-1:0]  fl_q;
	logic [1:0]          level_q;
	logic [PW-1:0]       page_q;
	logic [NW-1:0]       nfp_q;
	logic [PW-1:0]       zpage_q;
	logic [IDX_W-1:0]    zcnt_q;
	logic [ENTRY_W-1:0]  rdata_q;
	status_t             res_status_q;
	logic [PA_W-1:0]     res_paddr_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [PA_W-1:0]     out_paddr_q;

	logic [IDX_W-1:0]    idx;
	logic [FW-1:0]       ent_diff;
	logic [FW-1:0]       link_frame;
	logic [ENTRY_W-1:0]  link_entry;
	logic [ENTRY_W-1:0]  leaf_entry;
	logic [PA_W-1:0]     xlat;
	logic [AW-1:0]       addr;
	logic [ENTRY_W-1:0]  wdata;
	logic                we;
	logic                out_free;

	always_comb begin
		case (level_q)
			2'd0:    idx = va_q[47:39];
			2'd1:    idx = va_q[38:30];
			2'd2:    idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
	end

	// window offset of the entry's frame, wrapping at the physical width
	assign ent_diff   = rdata_q[PHYS_BITS-1:PAGE_OFF_W] - base_q;
	assign link_frame = base_q + FW'(zpage_q);
	assign link_entry = ENTRY_W'({link_frame, PAGE_OFF_W'(ENT_TABLE)});
	assign leaf_entry = (ENTRY_W'(pa_q) & FRAME_MASK) | fl_q;
	assign xlat       = PA_W'(rdata_q & FRAME_MASK) | PA_W'(va_q[PAGE_OFF_W-1:0]);

	assign addr = cmd.zero_wr ? {zpage_q, zcnt_q} : {page_q, idx};
	assign we   = cmd.zero_wr | cmd.link_wr | cmd.leaf_wr | cmd.clr_wr;

	always_comb begin
		if (cmd.link_wr) wdata = link_entry;
		else if (cmd.leaf_wr) wdata = leaf_entry;
		else wdata = '0;
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st              = '0;
		st.is_translate = (op_q == OP_TRANSLATE);
		st.is_map       = (op_q == OP_MAP);
		st.is_unmap     = (op_q == OP_UNMAP);
		st.noncanon     = (va_q[VA_W-1:CANON_LSB] != '0) && (va_q[VA_W-1:CANON_LSB] != '1);
		st.present      = rdata_q[0];
		st.in_win       = (ent_diff < FW'(TABLE_PAGES));
		st.at_leaf      = (level_q == LEAF_LEVEL);
		st.pages_left   = (nfp_q < NW'(TABLE_PAGES));
		st.zero_last    = (zcnt_q == IDX_W'(ENTRIES - 1));
		st.out_free     = out_free;
	end

	// table store, single port with registered read
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (cmd.rd) rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= table_base[PHYS_BITS-1:PAGE_OFF_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			va_q <= vaddr;
			pa_q <= paddr;
			fl_q <= flags;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			res_paddr_q  <= (st.is_translate && cmd.res_code == ST_OK) ? xlat : '0;
		end
		if (cmd.post) begin
			out_status_q <= res_status_q;
			out_paddr_q  <= res_paddr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= '0;
			page_q      <= '0;
			nfp_q       <= NW'(1);
			zpage_q     <= '0;
			zcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				level_q <= '0;
				page_q  <= '0;
			end else if (cmd.descend) begin
				level_q <= level_q + 2'd1;
				page_q  <= ent_diff[PW-1:0];
			end else if (cmd.link_wr) begin
				level_q <= level_q + 2'd1;
				page_q  <= zpage_q;
			end
			if (cmd.alloc) begin
				zpage_q <= nfp_q[PW-1:0];
				zcnt_q  <= '0;
				nfp_q   <= nfp_q + NW'(1);
			end else if (cmd.zero_wr) begin
				zcnt_q <= zcnt_q + IDX_W'(1);
			end
			if (cmd.post) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign paddr_out = out_paddr_q;

endmodule

// ===== design/four_level_page_table_walker_top.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// four-level page table walker with built-in table store and page allocator
// ----------------------------------------------------------------------------
// The block keeps an x86-64 style four-level page table in an internal store
// of TABLE_PAGES pages of 512 entries, seen at the physical window given by
// table_base (page 0 of the window is the root). op 0 translates vaddr and
// returns frame plus page offset, op 1 maps vaddr to paddr with the given
// flags (creating missing tables from a bump allocator), op 2 clears the leaf.
// One item is worked on at a time; each table level costs one store read
// (an address state then an evaluate state) on the single store port. A full
// walk for translate or unmap runs through decode, four reads and the result
// handoff, and the next request is taken once the result is handed off. A
// walk that stops at a missing or out-of-window table skips the reads of the
// levels below it, and a non-canonical address or the unused op answers
// straight after decode. A map that reaches the leaf also zeroes every new
// table, one entry per cycle, before it is linked. After reset the root page
// is cleared, during which in_stall stays high; table_base writes are taken
// at any time. The result register lets the next item be taken while a result
// waits on out_stall.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top import fptw_pkg::*; #(
	parameter int TABLE_PAGES = DEF_TABLE_PAGES,
	parameter int PHYS_BITS   = DEF_PHYS_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic [PA_W-1:0]     table_base,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     op,
	input  logic [VA_W-1:0]     vaddr,
	input  logic [PA_W-1:0]     paddr,
	input  logic [ENTRY_W-1:0]  flags,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [PA_W-1:0]     paddr_out
);

	cmd_t  cmd;  // sequencer commands
	stat_t st;   // datapath conditions

	// state machine: walk sequencing, allocation and result handoff
	fptw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// store, walk registers, allocator and output register
	fptw_dp #(
		.TABLE_PAGES (TABLE_PAGES),
		.PHYS_BITS   (PHYS_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_we     (cfg_we),
		.table_base (table_base),
		.op         (op),
		.vaddr      (vaddr),
		.paddr      (paddr),
		.flags      (flags),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.paddr_out  (paddr_out)
	);

endmodule

// ===== design/fptw_checker.sv =====
// ----------------------------------------------------------------------------
// fptw_checker
// port-level checks of the page table walker, bound to the top level
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_top_defines.svh"

module fptw_checker import fptw_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [PA_W-1:0]     paddr_out
);

	// only the five defined codes ever leave the block
	`FPTW_ASSERT_SAME(a_status_code, out_valid, status <= ST_NOPAGES, "status code out of range")

	// an address is only returned with an ok status
	`FPTW_ASSERT_SAME(a_paddr_zero, out_valid && status != ST_OK, paddr_out == '0, "address with error status")

	// one item at a time: busy right after a transfer in
	`FPTW_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "request taken while busy")

	// a stalled result holds
	`FPTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(paddr_out), "stalled result changed")

endmodule

bind four_level_page_table_walker_top fptw_checker u_fptw_checker (.*);

// ===== dv/walk_check_pkg.sv =====
// ----------------------------------------------------------------------------
// walk_check_pkg
// shadow page table and result scoreboard for the page table walker bench
// ----------------------------------------------------------------------------
package walk_check_pkg;
	import fptw_pkg::*;

	localparam int WALK_PAGES     = DEF_TABLE_PAGES;
	localparam int WALK_PHYS_BITS = DEF_PHYS_BITS;

	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	localparam bit [63:0] PHYS_MASK     = (64'd1 << WALK_PHYS_BITS) - 64'd1;
	localparam bit [63:0] FRAME_MASK    = PHYS_MASK & ~64'hfff;
	localparam bit [63:0] LOW_HALF_TOP  = 64'h0000_7fff_ffff_ffff;
	localparam bit [63:0] HIGH_HALF_BOT = 64'hffff_8000_0000_0000;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VA_W-1:0]    vaddr;
		logic [PA_W-1:0]    paddr;
		logic [ENTRY_W-1:0] flags;
	} walk_req_t;

	typedef struct packed {
		status_t         status;
		logic [PA_W-1:0] paddr;
	} walk_result_t;

	function automatic bit is_noncanonical(logic [VA_W-1:0] va);
		return (va > LOW_HALF_TOP) && (va < HIGH_HALF_BOT);
	endfunction

	class walk_scoreboard;
		bit [ENTRY_W-1:0] shadow_tables [WALK_PAGES*ENTRIES];
		int unsigned      next_page;
		bit [63:0]        window_base;
		walk_result_t     expected_results [$];
		int               errors;

		function new();
			next_page   = 1;
			window_base = '0;
			errors      = 0;
		endfunction

		function void set_base(logic [PA_W-1:0] value);
			window_base = {12'd0, value};
		endfunction

		function int unsigned entry_slot(int unsigned page, logic [VA_W-1:0] va, int level);
			int unsigned idx;
			idx = 32'((va >> (39 - 9 * level)) & 64'h1ff);
			return page * ENTRIES + idx;
		endfunction

		// window page an entry points at, offset taken modulo the physical space
		function bit window_page(bit [63:0] e, output int unsigned page);
			bit [63:0] off;
			off  = ((e & FRAME_MASK) - (window_base & FRAME_MASK)) & PHYS_MASK;
			page = 32'(off >> 12);
			return (off >> 12) < WALK_PAGES;
		endfunction

		// true when the walk would descend into a page the allocator never handed out
		function bit reaches_unwritten(walk_req_t req);
			int unsigned page;
			bit [63:0]   e;
			int          lvl;
			if (req.op == OP_RESERVED || is_noncanonical(req.vaddr))
				return 0;
			page = 0;
			for (lvl = 0; lvl < int'(LEAF_LEVEL); lvl++) begin
				e = shadow_tables[entry_slot(page, req.vaddr, lvl)];
				if (!e[0] || !window_page(e, page))
					return 0;
				if (page >= next_page)
					return 1;
			end
			return 0;
		endfunction

		function status_t map_leaf(walk_req_t req);
			int unsigned page;
			int unsigned slot;
			int unsigned np;
			bit [63:0]   e;
			int          lvl;
			page = 0;
			for (lvl = 0; lvl < int'(LEAF_LEVEL); lvl++) begin
				slot = entry_slot(page, req.vaddr, lvl);
				e    = shadow_tables[slot];
				if (!e[0]) begin
					if (next_page >= WALK_PAGES)
						return ST_NOPAGES;
					np = next_page;
					next_page++;
					for (int i = 0; i < ENTRIES; i++)
						shadow_tables[np * ENTRIES + i] = '0;
					shadow_tables[slot] = (((window_base & FRAME_MASK) + (64'(np) << 12))
						& FRAME_MASK) | {62'd0, ENT_TABLE};
					page = np;
				end else if (!window_page(e, page)) begin
					return ST_NOTMAPPED;
				end
			end
			slot = entry_slot(page, req.vaddr, int'(LEAF_LEVEL));
			if (shadow_tables[slot][0])
				return ST_MAPPED;
			shadow_tables[slot] = ({12'd0, req.paddr} & FRAME_MASK) | req.flags;
			return ST_OK;
		endfunction

		function walk_result_t predict_walk(walk_req_t req);
			walk_result_t res;
			int unsigned  page;
			int unsigned  slot;
			bit [63:0]    e;
			int           lvl;
			res.status = ST_OK;
			res.paddr  = '0;
			if (req.op == OP_RESERVED)
				return res;
			if (is_noncanonical(req.vaddr)) begin
				res.status = ST_NONCANON;
				return res;
			end
			if (req.op == OP_MAP) begin
				res.status = map_leaf(req);
				return res;
			end
			page = 0;
			for (lvl = 0; lvl < int'(LEAF_LEVEL); lvl++) begin
				e = shadow_tables[entry_slot(page, req.vaddr, lvl)];
				if (!e[0] || !window_page(e, page)) begin
					res.status = ST_NOTMAPPED;
					return res;
				end
			end
			slot = entry_slot(page, req.vaddr, int'(LEAF_LEVEL));
			e    = shadow_tables[slot];
			if (req.op == OP_TRANSLATE) begin
				if (e[0])
					res.paddr = PA_W'(((e & FRAME_MASK) + (req.vaddr & 64'hfff)) & PHYS_MASK);
				else
					res.status = ST_NOTMAPPED;
			end else begin
				shadow_tables[slot] = '0;
				if (!e[0])
					res.status = ST_NOTMAPPED;
			end
			return res;
		endfunction

		function void note_request(walk_req_t req);
			expected_results.push_back(predict_walk(req));
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [PA_W-1:0] paddr);
			walk_result_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d paddr_out %h", status, paddr);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				errors++;
			end
			if (paddr !== want.paddr) begin
				$error("paddr_out: expected %h, actual %h", want.paddr, paddr);
				errors++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the four-level page table walker
// ----------------------------------------------------------------------------
// A shadow copy of the table store predicts every result. A short directed
// run covers the canonical-hole edges, remaps, non-present leaves, the unused
// op and a moved window; random phases under several window bases then mix
// mostly related addresses with noise, one phase holds the result side off
// long enough to back up the request side, and a final phase drains the page
// allocator. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fptw_pkg::*;
	import walk_check_pkg::*;

	localparam int     HOLD_CYCLES     = 300;
	localparam int     DRAIN_TAIL      = 40;
	localparam int     ITEMS_PER_PHASE = 70;
	localparam longint LIMIT_NS        = 6_000_000;

	// window base with junk in the ignored page-offset bits
	localparam logic [PA_W-1:0] BASE_A = 52'h0_1234_5678_9abc;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [PA_W-1:0]     table_base;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [VA_W-1:0]     vaddr;
	logic [PA_W-1:0]     paddr;
	logic [ENTRY_W-1:0]  flags;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [PA_W-1:0]     paddr_out;

	walk_scoreboard walk_sb;

	// recently mapped addresses, reused to drive walks through live tables
	logic [VA_W-1:0] mapped_vas [$];

	bit sender_idle_on = 1'b1;
	bit hold_start     = 1'b0;
	int hold_left      = 0;
	int run_left       = 0;
	int stall_left     = 0;

	four_level_page_table_walker_top #(
		.TABLE_PAGES(WALK_PAGES),
		.PHYS_BITS  (WALK_PHYS_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.table_base(table_base),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.vaddr     (vaddr),
		.paddr     (paddr),
		.flags     (flags),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.paddr_out (paddr_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: runs of ready cycles broken by stalls, plus one long hold-off
	always @(negedge clk) begin
		if (hold_start) begin
			hold_start = 1'b0;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (run_left == 0 && stall_left == 0) begin
				// a few long ready runs give stretches with no stall at all
				run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
					: $urandom_range(1, 6);
				stall_left = gap_len();
			end
			if (run_left > 0) begin
				run_left--;
				out_stall <= 1'b0;
			end else begin
				stall_left--;
				out_stall <= 1'b1;
			end
		end
	end

	// every result transfer is checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			walk_sb.check_result(status, paddr_out);
	end

	function automatic walk_req_t request_of(logic [OP_W-1:0] o, logic [VA_W-1:0] va,
		logic [PA_W-1:0] pa, logic [ENTRY_W-1:0] fl);
		walk_req_t req;
		req.op    = o;
		req.vaddr = va;
		req.paddr = pa;
		req.flags = fl;
		return req;
	endfunction

	function automatic logic [VA_W-1:0] canonical_of(logic [47:0] low);
		return {{16{low[47]}}, low};
	endfunction

	function automatic logic [VA_W-1:0] pick_vaddr();
		int              r;
		logic [8:0]      i0;
		logic [8:0]      i1;
		logic [8:0]      i2;
		logic [VA_W-1:0] va;
		r = $urandom_range(0, 99);
		if (r < 45 && mapped_vas.size() > 0) begin
			va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
			if ($urandom_range(0, 1))
				va[11:0] = 12'($urandom);
			// neighbor leaf in the same last-level table
			if ($urandom_range(0, 3) == 0)
				va[20:12] = 9'($urandom);
			return va;
		end
		if (r < 80) begin
			// small set of upper indices so that tables get shared
			case ($urandom_range(0, 3))
				0: i0 = 9'd0;
				1: i0 = 9'd1;
				2: i0 = 9'd256;
				default: i0 = 9'd511;
			endcase
			case ($urandom_range(0, 2))
				0: i1 = 9'd0;
				1: i1 = 9'd7;
				default: i1 = 9'd511;
			endcase
			case ($urandom_range(0, 2))
				0: i2 = 9'd0;
				1: i2 = 9'd100;
				default: i2 = 9'd511;
			endcase
			return canonical_of({i0, i1, i2, 9'($urandom), 12'($urandom)});
		end
		if (r < 90)
			return canonical_of({16'($urandom), 32'($urandom)});
		if (r < 96)
			return {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return LOW_HALF_TOP;
			1: return LOW_HALF_TOP + 64'd1;
			2: return HIGH_HALF_BOT - 64'd1;
			3: return HIGH_HALF_BOT;
			4: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic walk_req_t pick_request();
		walk_req_t req;
		int        r;
		r = $urandom_range(0, 99);
		if (r < 40)
			req.op = OP_TRANSLATE;
		else if (r < 72)
			req.op = OP_MAP;
		else if (r < 95)
			req.op = OP_UNMAP;
		else
			req.op = OP_RESERVED;
		req.vaddr = pick_vaddr();
		req.paddr = {20'($urandom), 32'($urandom)};
		req.flags = {$urandom, $urandom};
		// mostly present leaves, some left non-present on purpose
		if ($urandom_range(0, 99) < 85)
			req.flags[0] = 1'b1;
		return req;
	endfunction

	// redraw until the walk stays inside pages that were handed out
	function automatic walk_req_t safe_request();
		walk_req_t req;
		for (int tries = 0; tries < 50; tries++) begin
			req = pick_request();
			if (!walk_sb.reaches_unwritten(req))
				return req;
		end
		req.op = OP_RESERVED;
		return req;
	endfunction

	// one request transfer, with an optional idle gap in front
	task automatic send_request(walk_req_t req);
		int gap;
		gap = sender_idle_on ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op       <= req.op;
		vaddr    <= req.vaddr;
		paddr    <= req.paddr;
		flags    <= req.flags;
		do @(posedge clk); while (in_stall !== 1'b0);
		walk_sb.note_request(req);
		if (req.op == OP_MAP && !is_noncanonical(req.vaddr)) begin
			mapped_vas.push_back(req.vaddr);
			if (mapped_vas.size() > 64)
				void'(mapped_vas.pop_front());
		end
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (walk_sb.pending() > 0)
			@(posedge clk);
	endtask

	task automatic write_base(logic [PA_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_we     <= 1'b1;
		table_base <= value;
		@(negedge clk);
		cfg_we     <= 1'b0;
		walk_sb.set_base(value);
	endtask

	task automatic run_random(int count, int hold_at);
		for (int n = 0; n < count; n++) begin
			// raised right after a request transfer, away from the stall driver
			if (n == hold_at)
				hold_start = 1'b1;
			send_request(safe_request());
		end
	endtask

	// keep mapping fresh top-level slots until the allocator runs dry
	task automatic exhaust_tables();
		walk_req_t req;
		int        tries;
		tries = 0;
		while (walk_sb.next_page < WALK_PAGES && tries < 200) begin
			req = request_of(OP_MAP, canonical_of({16'($urandom), 32'($urandom)}),
				{20'($urandom), 32'($urandom)}, {$urandom, $urandom} | 64'd1);
			if (!walk_sb.reaches_unwritten(req))
				send_request(req);
			tries++;
		end
		repeat (4) begin
			req = request_of(OP_MAP, canonical_of({16'($urandom), 32'($urandom)}),
				{20'($urandom), 32'($urandom)}, {$urandom, $urandom} | 64'd1);
			if (!walk_sb.reaches_unwritten(req))
				send_request(req);
		end
	endtask

	initial begin
		walk_sb    = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		table_base = '0;
		in_valid   = 1'b0;
		op         = '0;
		vaddr      = '0;
		paddr      = '0;
		flags      = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// the root clear after reset shows up as in_stall, the handshake waits it out
		write_base(BASE_A);

		// empty tables
		send_request(request_of(OP_TRANSLATE, 64'h0, '0, '0));
		send_request(request_of(OP_UNMAP, 64'h0, '0, '0));
		// first map builds three tables, then remap of a present leaf
		send_request(request_of(OP_MAP, 64'h0, 52'hf_ffff_ffff_ffff, 64'h1));
		send_request(request_of(OP_TRANSLATE, 64'hfff, '0, '0));
		send_request(request_of(OP_MAP, 64'h0, '0, 64'h1));
		// leaf written without the present bit
		send_request(request_of(OP_MAP, 64'h1000, 52'h0_0000_1234_5000, 64'h0));
		send_request(request_of(OP_TRANSLATE, 64'h1000, '0, '0));
		send_request(request_of(OP_UNMAP, 64'h1000, '0, '0));
		// both edges of the canonical hole, every op
		send_request(request_of(OP_MAP, LOW_HALF_TOP + 64'd1, '1, '1));
		send_request(request_of(OP_TRANSLATE, HIGH_HALF_BOT - 64'd1, '0, '0));
		send_request(request_of(OP_UNMAP, 64'h8000_0000_0000_0000, '0, '0));
		send_request(request_of(OP_MAP, LOW_HALF_TOP, '0, '1));
		send_request(request_of(OP_TRANSLATE, LOW_HALF_TOP, '0, '0));
		send_request(request_of(OP_MAP, HIGH_HALF_BOT, 52'h0_0000_0000_1000,
			64'h8000_0000_0000_0007));
		send_request(request_of(OP_TRANSLATE, '1, '0, '0));
		send_request(request_of(OP_MAP, '1, 52'h5_5555_5555_5555, 64'h3));
		send_request(request_of(OP_TRANSLATE, '1, '0, '0));
		send_request(request_of(OP_TRANSLATE, HIGH_HALF_BOT + 64'h123, '0, '0));
		// unused op code, loud payload
		send_request(request_of(OP_RESERVED, LOW_HALF_TOP + 64'd1, '1, '1));
		send_request(request_of(OP_UNMAP, 64'h0, '0, '0));
		send_request(request_of(OP_TRANSLATE, 64'h0, '0, '0));

		// moved window: old links now point outside it
		write_base('0);
		send_request(request_of(OP_TRANSLATE, LOW_HALF_TOP, '0, '0));
		send_request(request_of(OP_MAP, 64'h0, 52'h0_0000_0000_2000, 64'h1));
		send_request(request_of(OP_UNMAP, HIGH_HALF_BOT, '0, '0));
		send_request(request_of(OP_MAP, 64'h0000_0080_0000_0000, 52'h0_0000_0000_3000, 64'h1));
		// moved back, the old tables are reachable again
		write_base(BASE_A);
		send_request(request_of(OP_TRANSLATE, LOW_HALF_TOP, '0, '0));

		run_random(ITEMS_PER_PHASE, -1);

		// top page of the physical space, window wraps; back-to-back requests
		// against a long result hold-off fill the block up
		write_base('1);
		sender_idle_on = 1'b0;
		run_random(ITEMS_PER_PHASE, 12);
		sender_idle_on = 1'b1;

		write_base('0);
		run_random(ITEMS_PER_PHASE, -1);

		write_base({20'($urandom), 32'($urandom)});
		run_random(ITEMS_PER_PHASE, -1);

		write_base(BASE_A);
		exhaust_tables();
		run_random(ITEMS_PER_PHASE, -1);

		drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (walk_sb.errors == 0 && walk_sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/fptw_pkg.sv
design/fptw_ctrl.sv
design/fptw_dp.sv
design/four_level_page_table_walker_top.sv
design/fptw_checker.sv
dv/walk_check_pkg.sv
dv/tb_top.sv
